// ===== sv/fpst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared sizes, command codes and state encoding for the prefix sum table.
// ----------------------------------------------------------------------------
package fpst_pkg;

   localparam int SIZE     = 1024;
   localparam int ADDR_W   = $clog2(SIZE);
   localparam int IDX_W    = ADDR_W + 1;
   localparam int NODE_W   = IDX_W + 1;
   localparam int VAL_W    = 32;
   localparam int REQ_W    = 48;
   localparam int RSP_W    = 48;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_PREFIX = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_EXEC  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

// ===== sv/fpst_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpst_ram
// Generic single port RAM, read before write, registered read data.
// ----------------------------------------------------------------------------
module fpst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/fenwick_prefix_sum_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_table
// Binary indexed tree of 1024 wrapping 32-bit counters: add, prefix sum and
// threshold search, one node of the tree per fetch and execute step.
// ----------------------------------------------------------------------------
// After reset the block zeroes all 1024 nodes of the node memory, one node a
// cycle, and takes no beat meanwhile. Every item then walks the tree through
// the single port node memory, one item at a time: each visited node takes a
// fetch state, in which the node is read, and an execute state, in which it is
// accumulated or written back. An add visits at most 11 nodes, a prefix query
// at most 10, a search at most 11, and a prefix query with a zero bound or an
// ignored beat none; a query then loads the output register in its done state.
// A result waiting in the output register does not stop the next item from
// being taken, but the next result waits for it.
module fenwick_prefix_sum_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // position [10:0], operand [42:11], zero fill above
   input  logic [fpst_pkg::REQ_W-1:0] req_tdata,
   // cmd [1:0]
   input  logic [1:0]                req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // sum_out [31:0], found_index [42:32], zero fill above
   output logic [fpst_pkg::RSP_W-1:0] rsp_tdata
);

   import fpst_pkg::*;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   cmd_type            cmd_ff, cmd_in;
   logic [VAL_W-1:0]   operand_ff, operand_in;
   logic [NODE_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]   stride_ff, stride_in;
   logic [VAL_W-1:0]   acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]   sum_ff, sum_in;
   logic [IDX_W-1:0]   found_ff, found_in;

   logic [IDX_W-1:0]   req_position;
   logic [VAL_W-1:0]   req_operand;
   cmd_type            req_cmd;
   logic [NODE_W-1:0]  node_sel;
   logic [NODE_W-1:0]  low_bit;
   logic [NODE_W-1:0]  k_up;
   logic [VAL_W-1:0]   trial;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [VAL_W-1:0]   ram_wdata;
   logic [VAL_W-1:0]   ram_rdata;

   assign req_position = req_tdata[IDX_W-1:0];
   assign req_operand  = req_tdata[IDX_W+VAL_W-1:IDX_W];
   assign req_cmd      = cmd_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-VAL_W-IDX_W){1'b0}}, found_ff, sum_ff};

   assign node_sel = (cmd_ff != CMD_SEARCH) ? k_ff
                   : (stride_ff == IDX_W'(SIZE)) ? NODE_W'(SIZE)
                   : k_ff + NODE_W'(stride_ff);
   assign low_bit  = k_ff & (~k_ff + NODE_W'(1));
   assign k_up     = k_ff + low_bit;
   assign trial    = acc_ff + ram_rdata;

   assign ram_addr  = (state_ff == ST_CLEAR) ? clr_cnt_ff : ADDR_W'(node_sel - NODE_W'(1));
   assign ram_we    = (state_ff == ST_CLEAR) || (state_ff == ST_EXEC && cmd_ff == CMD_ADD);
   assign ram_wdata = (state_ff == ST_CLEAR) ? '0 : ram_rdata + operand_ff;

   fpst_ram #(
      .WIDTH (VAL_W),
      .DEPTH (SIZE)
   ) u_node_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      cmd_in       = cmd_ff;
      operand_in   = operand_ff;
      k_in         = k_ff;
      stride_in    = stride_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == ADDR_W'(SIZE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in     = req_cmd;
               operand_in = req_operand;
               acc_in     = '0;
               unique case (req_cmd)
                  CMD_ADD: begin
                     k_in = NODE_W'(req_position) + NODE_W'(1);
                     if (req_position < IDX_W'(SIZE)) begin
                        state_in = ST_FETCH;
                     end
                  end
                  CMD_PREFIX: begin
                     k_in = (req_position > IDX_W'(SIZE)) ? NODE_W'(SIZE)
                                                          : NODE_W'(req_position);
                     state_in = (req_position == '0) ? ST_DONE : ST_FETCH;
                  end
                  CMD_SEARCH: begin
                     k_in      = '0;
                     stride_in = IDX_W'(SIZE);
                     state_in  = ST_FETCH;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (cmd_ff)
               CMD_ADD: begin
                  k_in     = k_up;
                  state_in = (k_up > NODE_W'(SIZE)) ? ST_IDLE : ST_FETCH;
               end
               CMD_PREFIX: begin
                  acc_in   = trial;
                  k_in     = k_ff & (k_ff - NODE_W'(1));
                  state_in = ((k_ff & (k_ff - NODE_W'(1))) == '0) ? ST_DONE : ST_FETCH;
               end
               default: begin
                  if (stride_ff == IDX_W'(SIZE)) begin
                     if (ram_rdata < operand_ff) begin
                        k_in     = NODE_W'(SIZE);
                        state_in = ST_DONE;
                     end else begin
                        stride_in = IDX_W'(SIZE / 2);
                        state_in  = ST_FETCH;
                     end
                  end else begin
                     if (trial < operand_ff) begin
                        acc_in = trial;
                        k_in   = k_ff + NODE_W'(stride_ff);
                     end
                     stride_in = stride_ff >> 1;
                     state_in  = (stride_ff == IDX_W'(1)) ? ST_DONE : ST_FETCH;
                  end
               end
            endcase
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               sum_in       = (cmd_ff == CMD_PREFIX) ? acc_ff : '0;
               found_in     = (cmd_ff == CMD_SEARCH) ? IDX_W'(k_ff) : '0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      operand_ff <= operand_in;
      k_ff       <= k_in;
      stride_ff  <= stride_in;
      acc_ff     <= acc_in;
      sum_ff     <= sum_in;
      found_ff   <= found_in;
   end

`ifndef SYNTHESIS
   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_write_phase : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_EXEC))
      else $error("node write outside clear or execute step");

   a_node_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (node_sel != '0 && node_sel <= NODE_W'(SIZE)))
      else $error("tree walk left the node range");

   a_search_stride : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && cmd_ff == CMD_SEARCH) |-> $onehot(stride_ff))
      else $error("search stride not a power of two");

   a_done_exit : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_DONE || state_ff == ST_IDLE))
      else $error("result step left to a working state");
`endif

endmodule
